FILE: design/itoa128_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and character helpers for the 128-bit radix-to-ASCII converter.
// No dependencies; every other design file refers to this package by scoped names.
package itoa128_pkg;

	localparam int VALUE_WIDTH_DEF  = 128;
	localparam int CHARS_PER_RESULT = 4;
	localparam int COUNT_W          = 3;
	localparam int RADIX_W          = 6;
	localparam int DIGIT_W          = 6;
	localparam int CFG_IDX_W        = 2;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLUS  = 2'd2;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;

	typedef enum logic [1:0] {
		SGN_NONE,
		SGN_MINUS,
		SGN_PLUS
	} sign_t;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		logic               upper;
		sign_t              sign;
	} ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_PUT,
		ST_FLUSH
	} state_t;

	function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
		logic [7:0] base;
		if (d < RADIX_DEC) begin
			return CHAR_ZERO + {2'b00, d};
		end
		base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
		return base + {2'b00, d} - {2'b00, RADIX_DEC};
	endfunction

	function automatic logic [7:0] sign_char(input sign_t s);
		case (s)
			SGN_MINUS: return CHAR_MINUS;
			SGN_PLUS:  return CHAR_PLUS;
			default:   return 8'h00;
		endcase
	endfunction

endpackage

FILE: design/itoa128_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, input acceptance and sign classification.
// Depends on itoa128_pkg; feeds the transfer queue in front of itoa128_back.
module itoa128_front #(
	parameter int VALUE_WIDTH = itoa128_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [itoa128_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [itoa128_pkg::RADIX_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [63:0]                        value_low,
	input  logic [63:0]                        value_high,
	input  logic                               is_signed,
	input  logic                               q_full,
	output logic                               q_push,
	output itoa128_pkg::ctl_t                  push_ctl,
	output logic [VALUE_WIDTH-1:0]             push_mag
);

	logic [itoa128_pkg::RADIX_W-1:0] radix_q;
	logic                            upper_q;
	logic                            plus_q;
	logic [127:0]                    full_val;
	logic [VALUE_WIDTH-1:0]          masked;
	logic [itoa128_pkg::RADIX_W-1:0] r_eff;
	logic                            base10;
	logic                            neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= itoa128_pkg::RADIX_DEC;
			upper_q <= 1'b0;
			plus_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				itoa128_pkg::CFG_RADIX: radix_q <= cfg_data;
				itoa128_pkg::CFG_UPPER: upper_q <= cfg_data[0];
				itoa128_pkg::CFG_PLUS:  plus_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		full_val = {value_high, value_low};
		masked   = full_val[VALUE_WIDTH-1:0];
		if (radix_q < itoa128_pkg::RADIX_MIN) begin
			r_eff = itoa128_pkg::RADIX_MIN;
		end else if (radix_q > itoa128_pkg::RADIX_MAX) begin
			r_eff = itoa128_pkg::RADIX_MAX;
		end else begin
			r_eff = radix_q;
		end
		base10   = (r_eff == itoa128_pkg::RADIX_DEC);
		neg      = is_signed & base10 & masked[VALUE_WIDTH-1];
		push_mag = neg ? (~masked + VALUE_WIDTH'(1)) : masked;
		push_ctl.radix = r_eff;
		push_ctl.upper = upper_q;
		if (neg) begin
			push_ctl.sign = itoa128_pkg::SGN_MINUS;
		end else if (base10 && plus_q) begin
			push_ctl.sign = itoa128_pkg::SGN_PLUS;
		end else begin
			push_ctl.sign = itoa128_pkg::SGN_NONE;
		end
		in_ready = !q_full;
		q_push   = in_valid & !q_full;
	end

endmodule

FILE: design/itoa128_fifo.sv
`timescale 1ns / 1ps
// Short queue that decouples the front end from the conversion engine.
// Depends on itoa128_pkg for its depth.
module itoa128_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int PW = $clog2(itoa128_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(itoa128_pkg::QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [itoa128_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == CW'(itoa128_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: design/itoa128_back.sv
`timescale 1ns / 1ps
// Conversion engine: byte-serial division by the radix, digit stack memory and packing.
// Depends on itoa128_pkg; takes entries from itoa128_fifo and drives the result register.
module itoa128_back #(
	parameter int VALUE_WIDTH = itoa128_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  itoa128_pkg::ctl_t                  q_ctl,
	input  logic [VALUE_WIDTH-1:0]             q_mag,
	output logic                               q_pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         chars [itoa128_pkg::CHARS_PER_RESULT],
	output logic [itoa128_pkg::COUNT_W-1:0]    count,
	output logic                               last
);

	localparam int CPR    = itoa128_pkg::CHARS_PER_RESULT;
	localparam int NBYTES = (VALUE_WIDTH + 7) / 8;
	localparam int PADW   = NBYTES * 8;
	localparam int BCW    = $clog2(NBYTES + 1);
	localparam int PTRW   = $clog2(VALUE_WIDTH + 1);
	localparam int AW     = $clog2(VALUE_WIDTH);
	localparam int SLW    = itoa128_pkg::COUNT_W;
	localparam int SIW    = $clog2(CPR);
	localparam int DW     = itoa128_pkg::DIGIT_W;

	itoa128_pkg::state_t state_q, state_d;

	logic [PADW-1:0]               w_q;
	logic [DW-1:0]                 rem_q;
	logic                          nz_q;
	logic [itoa128_pkg::RADIX_W-1:0] radix_q;
	logic                          upper_q;
	logic [BCW-1:0]                byte_q;
	logic [PTRW-1:0]               ptr_q;
	logic [PTRW-1:0]               ptr_m1;
	logic [SLW-1:0]                slot_q;
	logic [7:0]                    pack_q [CPR];
	logic [7:0]                    char_q [CPR];
	logic [SLW-1:0]                count_q;
	logic                          last_q;
	logic                          out_valid_q;
	logic [DW-1:0]                 dmem [VALUE_WIDTH];
	logic [DW-1:0]                 rd_data_q;

	logic [7:0]    top_byte;
	logic [7:0]    qbyte;
	logic [DW-1:0] rem_t;
	logic [DW:0]   trial;
	logic [DW-1:0] rem_n;
	logic          last_byte;
	logic          more;
	logic          out_free;
	logic          mem_we;
	logic          out_load;

	always_comb begin
		top_byte = w_q[PADW-1 -: 8];
		rem_t    = rem_q;
		qbyte    = 8'h00;
		trial    = '0;
		for (int i = 7; i >= 0; i--) begin
			trial = {rem_t, top_byte[i]};
			if (trial >= {1'b0, radix_q}) begin
				qbyte[i] = 1'b1;
				rem_t    = DW'(trial - {1'b0, radix_q});
			end else begin
				rem_t = trial[DW-1:0];
			end
		end
		rem_n = rem_t;
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		out_load  = 1'b0;
		last_byte = (byte_q == BCW'(NBYTES - 1));
		more      = nz_q | (qbyte != 8'h00);
		out_free  = !out_valid_q | out_ready;
		mem_we    = (state_q == itoa128_pkg::ST_DIV) && last_byte;
		ptr_m1    = ptr_q - PTRW'(1);
		case (state_q)
			itoa128_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = itoa128_pkg::ST_DIV;
				end
			end
			itoa128_pkg::ST_DIV: begin
				if (last_byte && !more) begin
					state_d = (slot_q == SLW'(CPR)) ? itoa128_pkg::ST_FLUSH
						: itoa128_pkg::ST_RD;
				end
			end
			itoa128_pkg::ST_RD: begin
				state_d = itoa128_pkg::ST_PUT;
			end
			itoa128_pkg::ST_PUT: begin
				if (slot_q == SLW'(CPR - 1) || ptr_q == '0) begin
					state_d = itoa128_pkg::ST_FLUSH;
				end else begin
					state_d = itoa128_pkg::ST_RD;
				end
			end
			itoa128_pkg::ST_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = (ptr_q == '0) ? itoa128_pkg::ST_IDLE : itoa128_pkg::ST_RD;
				end
			end
			default: begin
				state_d = itoa128_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itoa128_pkg::ST_IDLE;
			byte_q      <= '0;
			ptr_q       <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				itoa128_pkg::ST_IDLE: begin
					if (q_valid) begin
						byte_q <= '0;
						ptr_q  <= '0;
						slot_q <= (q_ctl.sign != itoa128_pkg::SGN_NONE) ? SLW'(1) : '0;
					end
				end
				itoa128_pkg::ST_DIV: begin
					byte_q <= last_byte ? '0 : byte_q + BCW'(1);
					if (last_byte) begin
						ptr_q <= ptr_q + PTRW'(1);
					end
				end
				itoa128_pkg::ST_RD: begin
					ptr_q <= ptr_m1;
				end
				itoa128_pkg::ST_PUT: begin
					slot_q <= slot_q + SLW'(1);
				end
				itoa128_pkg::ST_FLUSH: begin
					if (out_load) begin
						slot_q <= '0;
					end
				end
				default: ;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			itoa128_pkg::ST_IDLE: begin
				if (q_valid) begin
					w_q     <= PADW'(q_mag);
					rem_q   <= '0;
					nz_q    <= 1'b0;
					radix_q <= q_ctl.radix;
					upper_q <= q_ctl.upper;
					for (int j = 1; j < CPR; j++) begin
						pack_q[j] <= '0;
					end
					pack_q[0] <= itoa128_pkg::sign_char(q_ctl.sign);
				end
			end
			itoa128_pkg::ST_DIV: begin
				w_q <= (w_q << 8) | PADW'(qbyte);
				if (last_byte) begin
					rem_q <= '0;
					nz_q  <= 1'b0;
				end else begin
					rem_q <= rem_n;
					nz_q  <= more;
				end
			end
			itoa128_pkg::ST_PUT: begin
				pack_q[slot_q[SIW-1:0]] <= itoa128_pkg::digit_char(rd_data_q, upper_q);
			end
			itoa128_pkg::ST_FLUSH: begin
				if (out_load) begin
					char_q  <= pack_q;
					count_q <= slot_q;
					last_q  <= (ptr_q == '0);
					pack_q  <= '{default: '0};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dmem[ptr_q[AW-1:0]] <= rem_n;
		end
		if (state_q == itoa128_pkg::ST_RD) begin
			rd_data_q <= dmem[ptr_m1[AW-1:0]];
		end
	end

	assign out_valid = out_valid_q;
	assign chars     = char_q;
	assign count     = count_q;
	assign last      = last_q;

endmodule

FILE: design/int128_to_radix_ascii_top.sv
`timescale 1ns / 1ps
// Radix 2..36 ASCII conversion of a 128-bit integer, four characters per result transfer.
// The byte-serial divider takes one byte per cycle and yields a digit after each full pass;
// each digit is then read back from the digit stack (ST_RD, then ST_PUT) and packed;
// each full result is flushed once the result register is free. The engine works on one
// item at a time and takes no new item from the queue until the last one is finished.
// A two-entry queue lets new items be taken while the engine works; results wait in a register.
// Asynchronous active-low reset clears control state and sets radix 10, lowercase, no plus sign.
module int128_to_radix_ascii_top #(
	parameter int VALUE_WIDTH = itoa128_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [itoa128_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [itoa128_pkg::RADIX_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [63:0]                        value_low,
	input  logic [63:0]                        value_high,
	input  logic                               is_signed,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         char_0,
	output logic [7:0]                         char_1,
	output logic [7:0]                         char_2,
	output logic [7:0]                         char_3,
	output logic [itoa128_pkg::COUNT_W-1:0]    char_count,
	output logic                               last_chunk
);

	localparam int QW = $bits(itoa128_pkg::ctl_t) + VALUE_WIDTH;

	logic                   q_push;
	logic                   q_full;
	logic                   q_pop;
	logic                   q_valid;
	itoa128_pkg::ctl_t      push_ctl;
	logic [VALUE_WIDTH-1:0] push_mag;
	logic [QW-1:0]          pop_data;
	itoa128_pkg::ctl_t      q_ctl;
	logic [VALUE_WIDTH-1:0] q_mag;
	logic [7:0]             chars [itoa128_pkg::CHARS_PER_RESULT];

	itoa128_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value_low (value_low),
		.value_high(value_high),
		.is_signed (is_signed),
		.q_full    (q_full),
		.q_push    (q_push),
		.push_ctl  (push_ctl),
		.push_mag  (push_mag)
	);

	itoa128_fifo #(
		.WIDTH(QW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({push_ctl, push_mag}),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (pop_data),
		.not_empty(q_valid)
	);

	assign q_ctl = pop_data[QW-1:VALUE_WIDTH];
	assign q_mag = pop_data[VALUE_WIDTH-1:0];

	itoa128_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ctl    (q_ctl),
		.q_mag    (q_mag),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.chars    (chars),
		.count    (char_count),
		.last     (last_chunk)
	);

	assign char_0 = chars[0];
	assign char_1 = chars[1];
	assign char_2 = chars[2];
	assign char_3 = chars[3];

`ifndef SYNTH
	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("engine took an entry from an empty queue");

	a_transfer_queued: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> q_valid)
		else $error("accepted transfer did not reach the queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> char_count != '0
			&& char_count <= itoa128_pkg::COUNT_W'(itoa128_pkg::CHARS_PER_RESULT))
		else $error("result character count out of range");

	a_short_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_count < itoa128_pkg::COUNT_W'(itoa128_pkg::CHARS_PER_RESULT)
			|-> last_chunk)
		else $error("partial result not marked as final");
`endif

endmodule
